// ===== rtl/core/hsmt_pkg.sv =====
// ============================================================================
// hsmt_pkg
// shared widths, operation codes and default sizes of the hash set table
// ============================================================================
package hsmt_pkg;

    localparam int VALUE_W = 32;
    localparam int OP_W    = 2;

    // default table geometry
    localparam int DEF_BUCKETS = 64;
    localparam int DEF_WAYS    = 4;

    // operation codes
    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_TEST   = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    // result status codes
    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

endpackage

// ===== rtl/core/hsmt_in_if.sv =====
// ============================================================================
// hsmt_in_if
// request channel: operation and value with valid/ready handshake
// ============================================================================
interface hsmt_in_if;
    import hsmt_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           operation;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

// ===== rtl/core/hsmt_out_if.sv =====
// ============================================================================
// hsmt_out_if
// result channel: presence flag and status with valid/ready handshake
// ============================================================================
interface hsmt_out_if;
    import hsmt_pkg::*;

    logic valid;
    logic ready;
    logic was_present;
    logic status;

    modport source (output valid, output was_present, output status, input ready);
    modport sink   (input valid, input was_present, input status, output ready);
endinterface

// ===== rtl/core/hash_set_membership_table_top.sv =====
// ============================================================================
// hash_set_membership_table_top
// set of signed 32-bit words in a bucketed table, add / test / remove
// ============================================================================
//
//  channel  dir  handshake     word contents
//  i_in     in   valid/ready   operation (2b), value (32b signed)
//  o_out    out  valid/ready   was_present (1b), status (1b)
//
//  one word in flight: the residue unit (reciprocal multiply, reduce, sign
//  fold), then a row read and an update; the next word is accepted only
//  once the update is done
//  after reset a clearing pass writes every bucket row, and i_in.ready
//  stays low until it ends
//  a held result stalls only the update cycle; the next word is accepted while
//  the result register still waits
//
module hash_set_membership_table_top #(
    parameter int BUCKETS = hsmt_pkg::DEF_BUCKETS,
    parameter int WAYS    = hsmt_pkg::DEF_WAYS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    hsmt_in_if.sink           i_in,
    hsmt_out_if.source        o_out
);
    import hsmt_pkg::*;

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

    // controller states
    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_HASH = 3'd2;
    localparam logic [2:0] ST_CMP  = 3'd3;

    // bucket rows: valid marks and stored values, same address
    logic [WAYS-1:0]              mem_valid [BUCKETS];
    logic [WAYS-1:0][VALUE_W-1:0] mem_vals  [BUCKETS];

    logic [2:0]                   r_state, n_state;
    logic [BW-1:0]                r_clr_addr;
    logic [OP_W-1:0]              r_op;
    logic [VALUE_W-1:0]           r_value;
    logic [BW-1:0]                r_bucket;
    logic [WAYS-1:0]              r_rd_valid;
    logic [WAYS-1:0][VALUE_W-1:0] r_rd_vals;
    logic                         r_out_valid, r_out_present, r_out_status;

    logic                         in_fire, hash_done, upd_fire, out_free;
    logic [BW-1:0]                hash_bucket;
    logic [WAYS-1:0]              hit_vec, hit_first, free_vec, free_first;
    logic                         any_hit, any_free;
    logic [WAYS-1:0]              n_valid_row;
    logic [WAYS-1:0][VALUE_W-1:0] n_vals_row;
    logic                         n_status;

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign upd_fire = (r_state == ST_CMP) && out_free;

    assign i_in.ready = (r_state == ST_IDLE);

    // bucket index of the accepted word
    hsmt_residue #(
        .BUCKETS (BUCKETS)
    ) u_residue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (in_fire),
        .i_value  ($unsigned(i_in.value)),
        .o_done   (hash_done),
        .o_bucket (hash_bucket)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLR:  if (r_clr_addr == BW'(BUCKETS - 1)) n_state = ST_IDLE;
            ST_IDLE: if (in_fire) n_state = ST_HASH;
            ST_HASH: if (hash_done) n_state = ST_CMP;
            ST_CMP:  if (out_free) n_state = ST_IDLE;
            default: n_state = ST_CLR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op    <= i_in.operation;
            r_value <= $unsigned(i_in.value);
        end
        if (hash_done) begin
            r_bucket <= hash_bucket;
        end
    end

    // row read, issued as the bucket index comes out
    always_ff @(posedge i_clk) begin
        if (hash_done) begin
            r_rd_valid <= mem_valid[hash_bucket];
            r_rd_vals  <= mem_vals[hash_bucket];
        end
    end

    // compare the whole row at once, lowest matching and lowest free way
    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            hit_vec[w] = r_rd_valid[w] && (r_rd_vals[w] == r_value);
        end
        free_vec   = ~r_rd_valid;
        hit_first  = hit_vec & (~hit_vec + 1'b1);
        free_first = free_vec & (~free_vec + 1'b1);
        any_hit    = |hit_vec;
        any_free   = |free_vec;
    end

    // row update
    always_comb begin
        n_valid_row = r_rd_valid;
        n_vals_row  = r_rd_vals;
        n_status    = STATUS_DONE;
        case (r_op)
            OP_ADD: begin
                if (!any_hit) begin
                    if (any_free) begin
                        n_valid_row = r_rd_valid | free_first;
                        for (int w = 0; w < WAYS; w++) begin
                            if (free_first[w]) n_vals_row[w] = r_value;
                        end
                    end else begin
                        n_status = STATUS_FULL;
                    end
                end
            end
            OP_REMOVE: begin
                n_valid_row = r_rd_valid & ~hit_first;
            end
            default: begin
                // test and the unused code leave the row alone
                n_valid_row = r_rd_valid;
            end
        endcase
    end

    // write port: clearing pass after reset, then read-modify-write
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CLR) begin
            mem_valid[r_clr_addr] <= '0;
        end else if (upd_fire) begin
            mem_valid[r_bucket] <= n_valid_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (upd_fire) begin
            mem_vals[r_bucket] <= n_vals_row;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (upd_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (upd_fire) begin
            r_out_present <= any_hit;
            r_out_status  <= n_status;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.was_present = r_out_present;
    assign o_out.status      = r_out_status;

endmodule

// ===== rtl/core/hsmt_residue.sv =====
// ============================================================================
// hsmt_residue
// non-negative residue of a signed word modulo BUCKETS, reciprocal multiply
// ============================================================================
module hsmt_residue #(
    parameter int BUCKETS = hsmt_pkg::DEF_BUCKETS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic [hsmt_pkg::VALUE_W-1:0]           i_value,
    output logic                                   o_done,
    output logic [(BUCKETS > 1 ? $clog2(BUCKETS) : 1)-1:0] o_bucket
);
    import hsmt_pkg::*;

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    // floor(2^VALUE_W / BUCKETS): the quotient estimate is exact or one short
    localparam longint RECIP = (longint'(1) << VALUE_W) / BUCKETS;
    localparam logic [VALUE_W-1:0] RECIP_W = VALUE_W'(RECIP);
    // 2^VALUE_W mod BUCKETS, removed again for negative words
    localparam longint WRAP = (longint'(1) << VALUE_W) % BUCKETS;
    localparam logic [BW:0] B_EXT = (BW + 1)'(BUCKETS);
    localparam logic [BW:0] ADJ   = (BW + 1)'(BUCKETS - WRAP);

    logic                 r_v_val, r_v_quo, r_v_rem, r_done, r_neg;
    logic [VALUE_W-1:0]   r_val;
    logic [BW:0]          r_quo;
    logic [BW-1:0]        r_rem, r_bucket;
    logic [BW-1:0]        n_rem, n_bucket;
    logic [2*VALUE_W-1:0] prod;
    logic [BW:0]          qd, est, fix_sum;

    // quotient estimate, low BW + 1 bits of the upper half of the product
    assign prod = {{VALUE_W{1'b0}}, r_val} * {{VALUE_W{1'b0}}, RECIP_W};

    // remainder in the low bits only, below 2 * BUCKETS, one compare-subtract
    always_comb begin
        qd  = r_quo * B_EXT;
        est = r_val[BW:0] - qd;
        if (est >= B_EXT) begin
            est = est - B_EXT;
        end
        n_rem = est[BW-1:0];
    end

    // fold the unsigned residue back to the signed one
    always_comb begin
        fix_sum = {1'b0, r_rem} + ADJ;
        if (fix_sum >= B_EXT) begin
            fix_sum = fix_sum - B_EXT;
        end
        n_bucket = r_neg ? fix_sum[BW-1:0] : r_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_val <= 1'b0;
            r_v_quo <= 1'b0;
            r_v_rem <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_v_val <= i_start;
            r_v_quo <= r_v_val;
            r_v_rem <= r_v_quo;
            r_done  <= r_v_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val <= i_value;
            r_neg <= i_value[VALUE_W-1];
        end
        if (r_v_val) begin
            r_quo <= prod[VALUE_W +: BW + 1];
        end
        if (r_v_quo) begin
            r_rem <= n_rem;
        end
        if (r_v_rem) begin
            r_bucket <= n_bucket;
        end
    end

    assign o_done   = r_done;
    assign o_bucket = r_bucket;

endmodule
